// ----- design/assert_macros.svh -----
// Assertion macros used by the filter design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property with reset disable, for modules that have clk and rst_n.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication that must hold from one cycle to the next.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- design/cvtf_pkg.sv -----
// Package with the types and constants of the verb table filter.
package cvtf_pkg;

    localparam int WORD_W     = 32;
    localparam int JACK_SHIFT = 2;                 // four body words per jack
    localparam int LEFT_W     = WORD_W + JACK_SHIFT;

    typedef enum logic [1:0] {
        POS_ID     = 2'd0,
        POS_SUBSYS = 2'd1,
        POS_COUNT  = 2'd2,
        POS_BODY   = 2'd3
    } pos_t;

    typedef enum logic {
        KIND_VERB   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic              result_kind;
        logic [WORD_W-1:0] verb_word;
        logic              found;
        logic              is_last;
    } result_t;

endpackage

// ----- design/cvtf_if.sv -----
// Channel interfaces: table words in, results out and the codec id write port.
interface cvtf_in_if;
    logic                        valid;
    logic                        ready;
    logic [cvtf_pkg::WORD_W-1:0] table_word;
    logic                        last_word;
    modport source (output valid, output table_word, output last_word, input ready);
    modport sink (input valid, input table_word, input last_word, output ready);
endinterface

interface cvtf_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [cvtf_pkg::WORD_W-1:0] verb_word;
    logic                        found;
    logic                        is_last;
    modport source (output valid, output result_kind, output verb_word, output found,
                    output is_last, input ready);
    modport sink (input valid, input result_kind, input verb_word, input found,
                  input is_last, output ready);
endinterface

interface cvtf_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cvtf_pkg::WORD_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/codec_verb_table_filter.sv -----
// Top level of the codec verb table filter.
//
// The block reads a concatenated verb table one 32-bit word per beat and
// forwards the body words of the first section whose vendor/device id equals
// codec_id, each as a verb result; every other word is swallowed. On the beat
// marked last_word it adds an end-of-table status result whose found bit says
// whether a matching section with a nonzero jack count was seen, and then it
// starts afresh for the next table. A table word is taken in every cycle in
// which the input is ready: the header and body tracking is a single compare
// and counter update done in the same cycle as the word is accepted. Results
// leave through a three-entry output queue, one per beat, so the sustained
// rate is one table word per cycle while the output does not stall, except
// that a last word which is itself a verb yields two results, which leave on
// separate beats. The input is ready whenever the queue holds at most one
// result, which keeps ready independent of the downstream ready in the same
// cycle. codec_id may only be rewritten while the block is idle; the write
// port is always ready and the new id applies from the next table word.
`include "assert_macros.svh"

module codec_verb_table_filter (
    input  logic            clk,
    input  logic            rst_n,
    cvtf_in_if.sink         tbl,
    cvtf_out_if.source      res,
    cvtf_cfg_if.sink        cfg
);

    localparam int QDEPTH = 3;

    // Configuration register.
    logic [cvtf_pkg::WORD_W-1:0] codec_id_reg;

    // Search state.
    cvtf_pkg::pos_t              pos_reg, pos_next;
    logic                        match_reg, match_next;
    logic [cvtf_pkg::LEFT_W-1:0] left_reg, left_next;
    logic                        fin_reg, fin_next;
    logic                        nonempty_reg, nonempty_next;

    // Output queue, entry 0 is the head.
    cvtf_pkg::result_t q_reg [QDEPTH];
    cvtf_pkg::result_t q_next [QDEPTH];
    logic [1:0]        cnt_reg, cnt_next;

    logic              acc;
    logic              pop;
    logic              has_verb;
    logic [1:0]        npush;
    logic [1:0]        base;
    cvtf_pkg::result_t first_res, second_res, verb_res, status_res;
    logic [cvtf_pkg::LEFT_W-1:0] left_dec;

    assign cfg.ready = 1'b1;

    assign tbl.ready = (cnt_reg <= 2'd1);
    assign acc       = tbl.valid && tbl.ready;

    assign res.valid       = (cnt_reg != 2'd0);
    assign res.result_kind = q_reg[0].result_kind;
    assign res.verb_word   = q_reg[0].verb_word;
    assign res.found       = q_reg[0].found;
    assign res.is_last     = q_reg[0].is_last;
    assign pop             = res.valid && res.ready;

    // Header and body tracking for the word on the input.
    always_comb
    begin
        pos_next      = pos_reg;
        match_next    = match_reg;
        left_next     = left_reg;
        fin_next      = fin_reg;
        nonempty_next = nonempty_reg;
        has_verb      = 1'b0;
        left_dec      = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
        if (!fin_reg)
        begin
            unique case (pos_reg)
                cvtf_pkg::POS_ID:
                begin
                    match_next = (tbl.table_word == codec_id_reg);
                    pos_next   = cvtf_pkg::POS_SUBSYS;
                end
                cvtf_pkg::POS_SUBSYS:
                begin
                    pos_next = cvtf_pkg::POS_COUNT;
                end
                cvtf_pkg::POS_COUNT:
                begin
                    left_next = {tbl.table_word, {cvtf_pkg::JACK_SHIFT{1'b0}}};
                    if (match_reg)
                    begin
                        nonempty_next = (tbl.table_word != '0);
                        if (tbl.table_word == '0)
                        begin
                            fin_next = 1'b1;
                        end
                    end
                    pos_next = (tbl.table_word == '0) ? cvtf_pkg::POS_ID
                                                      : cvtf_pkg::POS_BODY;
                end
                cvtf_pkg::POS_BODY:
                begin
                    has_verb  = match_reg;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        pos_next = cvtf_pkg::POS_ID;
                        if (match_reg)
                        begin
                            fin_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    pos_next = cvtf_pkg::POS_ID;
                end
            endcase
        end

        // The status reports what this word leaves behind, then the search
        // returns to its start for the next table.
        status_res.result_kind = cvtf_pkg::KIND_STATUS;
        status_res.verb_word   = '0;
        status_res.found       = nonempty_next;
        status_res.is_last     = 1'b1;

        verb_res.result_kind = cvtf_pkg::KIND_VERB;
        verb_res.verb_word   = tbl.table_word;
        verb_res.found       = 1'b0;
        verb_res.is_last     = !tbl.last_word;

        if (tbl.last_word)
        begin
            pos_next      = cvtf_pkg::POS_ID;
            match_next    = 1'b0;
            left_next     = '0;
            fin_next      = 1'b0;
            nonempty_next = 1'b0;
        end
    end

    // Queue update: shift on a pop, then append up to two results.
    always_comb
    begin
        first_res  = has_verb ? verb_res : status_res;
        second_res = status_res;
        npush      = acc ? ({1'b0, has_verb} + {1'b0, tbl.last_word}) : 2'd0;
        base       = cnt_reg - {1'b0, pop};
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && (i < QDEPTH - 1))
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if ((npush != 2'd0) && (base == 2'(i)))
            begin
                q_next[i] = first_res;
            end
            if ((npush == 2'd2) && ((base + 2'd1) == 2'(i)))
            begin
                q_next[i] = second_res;
            end
        end
        cnt_next = base + npush;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_id_reg <= '0;
            pos_reg      <= cvtf_pkg::POS_ID;
            match_reg    <= 1'b0;
            left_reg     <= '0;
            fin_reg      <= 1'b0;
            nonempty_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                codec_id_reg <= cfg.data;
            end
            if (acc)
            begin
                pos_reg      <= pos_next;
                match_reg    <= match_next;
                left_reg     <= left_next;
                fin_reg      <= fin_next;
                nonempty_reg <= nonempty_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Queue payload carries no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    // Inside a body there is always at least one word still to come.
    `ASSERT_CLK(a_body_left, (pos_reg != cvtf_pkg::POS_BODY) || (left_reg != '0), "body with no words left")
    // A finished search only follows a matching section and waits at a header.
    `ASSERT_CLK(a_fin_state, !fin_reg || (match_reg && (pos_reg == cvtf_pkg::POS_ID)), "finished search in wrong state")
    // The last word of a table leaves the search at its start.
    `ASSERT_NEXT(a_last_clears, acc && tbl.last_word, (pos_reg == cvtf_pkg::POS_ID) && !fin_reg && !nonempty_reg && !match_reg, "search not cleared after last word")

endmodule

// ----- bench/codec_verb_table_filter_checker.sv -----
// Checker for the codec verb table filter: tracks the table, predicts results, compares beats.
`timescale 1ns / 1ps

module codec_verb_table_filter_checker
    import cvtf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cvtf_in_if         tbl,
    cvtf_out_if        res,
    cvtf_cfg_if        cfg,
    output int         mismatches,
    output int         results_due,
    output int         verbs_seen,
    output int         statuses_seen
);

    logic [WORD_W-1:0] wanted_id;
    pos_t              hdr_pos;
    logic              sect_match;
    logic [LEFT_W-1:0] words_left;
    logic              search_done;
    logic              match_nonempty;
    result_t           verbs_due[$];

    // Advances the section tracking by one table word and queues what it yields.
    task automatic filter_word(input logic [WORD_W-1:0] word, input logic last);
        result_t r;
        if (!search_done)
        begin
            case (hdr_pos)
                POS_ID:
                begin
                    sect_match = (word == wanted_id);
                    hdr_pos    = POS_SUBSYS;
                end
                POS_SUBSYS:
                begin
                    hdr_pos = POS_COUNT;
                end
                POS_COUNT:
                begin
                    words_left = LEFT_W'(word) << JACK_SHIFT;
                    if (sect_match)
                    begin
                        match_nonempty = (word != '0);
                        if (word == '0)
                            search_done = 1'b1;
                    end
                    hdr_pos = (word == '0) ? POS_ID : POS_BODY;
                end
                default:
                begin
                    if (sect_match)
                    begin
                        r.result_kind = KIND_VERB;
                        r.verb_word   = word;
                        r.found       = 1'b0;
                        r.is_last     = !last;
                        verbs_due.push_back(r);
                    end
                    if (words_left != '0)
                        words_left = words_left - 1'b1;
                    if (words_left == '0)
                    begin
                        hdr_pos = POS_ID;
                        if (sect_match)
                            search_done = 1'b1;
                    end
                end
            endcase
        end
        if (last)
        begin
            r.result_kind = KIND_STATUS;
            r.verb_word   = '0;
            r.found       = match_nonempty;
            r.is_last     = 1'b1;
            verbs_due.push_back(r);
            hdr_pos        = POS_ID;
            sect_match     = 1'b0;
            words_left     = '0;
            search_done    = 1'b0;
            match_nonempty = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            wanted_id      = '0;
            hdr_pos        = POS_ID;
            sect_match     = 1'b0;
            words_left     = '0;
            search_done    = 1'b0;
            match_nonempty = 1'b0;
            verbs_due.delete();
            mismatches    <= 0;
            results_due   <= 0;
            verbs_seen    <= 0;
            statuses_seen <= 0;
        end
        else
        begin
            // Results are registered, so a beat leaving now was caused by an earlier word.
            if (res.valid && res.ready)
            begin
                if (verbs_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat kind=%0b verb=%h found=%0b last=%0b",
                             $time, res.result_kind, res.verb_word, res.found, res.is_last);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = verbs_due.pop_front();
                    if (res.result_kind !== want.result_kind || res.verb_word !== want.verb_word
                        || res.found !== want.found || res.is_last !== want.is_last)
                    begin
                        $display("%0t: result mismatch, expected kind=%0b verb=%h found=%0b last=%0b",
                                 $time, want.result_kind, want.verb_word, want.found,
                                 want.is_last);
                        $display("%0t:                  actual kind=%0b verb=%h found=%0b last=%0b",
                                 $time, res.result_kind, res.verb_word, res.found, res.is_last);
                        mismatches <= mismatches + 1;
                    end
                    if (want.result_kind == KIND_STATUS)
                        statuses_seen <= statuses_seen + 1;
                    else
                        verbs_seen <= verbs_seen + 1;
                end
            end
            // A word taken at this edge still sees the old id; a new id applies from the
            // next word on.
            if (tbl.valid && tbl.ready)
                filter_word(tbl.table_word, tbl.last_word);
            if (cfg.valid && cfg.ready)
                wanted_id = cfg.data;
            results_due <= verbs_due.size();
        end
    end

endmodule

// ----- bench/codec_verb_table_filter_test.sv -----
// Top of the verb table filter bench: clock, reset, table stimulus and the verdict.
`timescale 1ns / 1ps

module codec_verb_table_filter_test;
    import cvtf_pkg::*;

    // Generous ceiling: at most about 1700 words, each with its worst source gap and
    // two results each at their worst hold-off, come to roughly an eighth of this.
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int PHASE_WORDS   = 350;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [WORD_W-1:0] DIRECTED_ID = 32'hA5C3_0F1E;

    logic clk;
    logic rst_n;

    cvtf_in_if  tbl_ch ();
    cvtf_out_if res_ch ();
    cvtf_cfg_if cfg_ch ();

    int mismatches;
    int results_due;
    int verbs_seen;
    int statuses_seen;

    int words_sent;
    int tables_played;
    int ids_used;
    int cycle_count;

    // Whether the table source and the result sink insert random gaps; both are
    // redrawn for each table so that some tables stream back to back.
    logic src_gaps;
    logic sink_stalls;

    logic [WORD_W-1:0] table_words[$];

    codec_verb_table_filter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tbl   (tbl_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    codec_verb_table_filter_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .tbl           (tbl_ch),
        .res           (res_ch),
        .cfg           (cfg_ch),
        .mismatches    (mismatches),
        .results_due   (results_due),
        .verbs_seen    (verbs_seen),
        .statuses_seen (statuses_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Safety net: a hung handshake ends the run here rather than running forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("codec_verb_table_filter_test: errors");
            $finish;
        end
    end

    // Result sink. For every beat it draws a random hold-off (when stalls are
    // enabled), then keeps ready high until a beat has gone through.
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = sink_stalls ? $urandom_range(0, 9) : 0;
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            @(negedge clk);
        end
    end

    // Presents one table word at a falling edge and waits for the beat to be taken.
    // Valid is left high afterwards; the next call or the idle wait decides its fate,
    // so it is never lowered and raised within the same time step.
    task automatic send_word(input logic [WORD_W-1:0] word, input logic last);
        int gap;
        gap = src_gaps ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            tbl_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tbl_ch.valid      <= 1'b1;
        tbl_ch.table_word <= word;
        tbl_ch.last_word  <= last;
        do
            @(posedge clk);
        while (!tbl_ch.ready);
        @(negedge clk);
        words_sent++;
    endtask

    // Streams the words held in table_words, marking the final one as the table end.
    task automatic play_table();
        for (int i = 0; i < table_words.size(); i++)
            send_word(table_words[i], i == table_words.size() - 1);
        tables_played++;
    endtask

    // Drains the block: every predicted result must be back, and since most words
    // produce nothing the pipeline is then given a settling wait before a rewrite.
    task automatic wait_idle();
        tbl_ch.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_codec_id(input logic [WORD_W-1:0] id);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= id;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        ids_used++;
    endtask

    initial
    begin
        logic [WORD_W-1:0] phase_ids[4];
        logic [WORD_W-1:0] cur_id;
        logic [WORD_W-1:0] jacks;
        int                shape;
        int                body;
        int                keep;
        int                start;

        rst_n             <= 1'b0;
        tbl_ch.valid      <= 1'b0;
        tbl_ch.table_word <= '0;
        tbl_ch.last_word  <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        src_gaps          <= 1'b1;
        sink_stalls       <= 1'b1;
        words_sent         = 0;
        tables_played      = 0;
        ids_used           = 0;
        cycle_count       <= 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed tables, all under one fixed codec id.
        write_codec_id(DIRECTED_ID);

        // A foreign section with no jacks, then the wanted one with a single jack
        // whose fourth verb is also the last word, so it yields a verb and a status.
        table_words = '{32'h0BAD_F00D, 32'h0000_0000, 32'h0000_0000,
                        DIRECTED_ID, 32'h1234_5678, 32'h0000_0001,
                        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE};
        play_table();

        // The wanted section has zero jacks: the search stops, nothing after it counts
        // and found stays low.
        table_words = '{DIRECTED_ID, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000};
        play_table();

        // The table ends inside the header.
        table_words = '{DIRECTED_ID, 32'h5555_AAAA};
        play_table();

        // A full-range jack count, cut short after two body words.
        table_words = '{DIRECTED_ID, 32'hAAAA_5555, 32'hFFFF_FFFF,
                        32'h0000_0000, 32'hFFFF_FFFF};
        play_table();

        // Random phases, the first two at the extremes of the id range.
        phase_ids = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom};
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            write_codec_id(phase_ids[p]);
            cur_id = phase_ids[p];
            start  = words_sent;
            while (words_sent - start < PHASE_WORDS)
            begin
                table_words.delete();
                src_gaps    <= ($urandom_range(0, 3) != 0);
                sink_stalls <= ($urandom_range(0, 3) != 0);
                shape = $urandom_range(0, 9);
                if (shape == 0)
                begin
                    // Pure noise: random words with no structure behind them.
                    repeat ($urandom_range(1, 12)) table_words.push_back($urandom);
                end
                else
                begin
                    // Well-formed sections, half of them carrying the wanted id and
                    // some of the rest missing it by a single bit.
                    repeat ($urandom_range(1, 4))
                    begin
                        if ($urandom_range(0, 1) == 0)
                            table_words.push_back(cur_id);
                        else if ($urandom_range(0, 1) == 0)
                            table_words.push_back(cur_id ^ (32'h1 << $urandom_range(0, 31)));
                        else
                            table_words.push_back($urandom);
                        table_words.push_back($urandom);
                        jacks = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3);
                        table_words.push_back(jacks);
                        // An enormous jack count is followed by only a handful of words.
                        body = (jacks > 3) ? $urandom_range(1, 12) : 4 * int'(jacks);
                        repeat (body) table_words.push_back($urandom);
                    end
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 4)) table_words.push_back($urandom);
                    // Some tables are truncated at an arbitrary word.
                    if (shape <= 2)
                    begin
                        keep = $urandom_range(1, table_words.size());
                        while (table_words.size() > keep)
                            void'(table_words.pop_back());
                    end
                end
                play_table();
            end
        end

        wait_idle();
        $display("Run covered %0d table words in %0d tables under %0d codec ids,",
                 words_sent, tables_played, ids_used);
        $display("with %0d verb beats and %0d end-of-table status beats checked.",
                 verbs_seen, statuses_seen);
        if (results_due != 0)
            $display("%0t: %0d expected results never arrived", $time, results_due);
        if (mismatches == 0 && results_due == 0)
            $display("codec_verb_table_filter_test: clean");
        else
            $display("codec_verb_table_filter_test: errors");
        $finish;
    end

endmodule

// ----- codec_verb_table_filter.f -----
+incdir+design
design/cvtf_pkg.sv
design/cvtf_if.sv
design/codec_verb_table_filter.sv
bench/codec_verb_table_filter_checker.sv
bench/codec_verb_table_filter_test.sv
